// File: rtl/rap_pkg.sv
// Package for the reconfigurable array placer.
// Holds sizes, constants, payload structs, controller states and command structs.
`timescale 1ns / 1ps
`default_nettype none
package rap_pkg;
    localparam int MAX_ROWS    = 24;
    localparam int MAX_COLUMNS = 16;
    localparam int NUM_REGS    = 32;
    localparam int ROW_W       = $clog2(MAX_ROWS + 1);
    localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
    localparam int RIDX_W      = $clog2(MAX_ROWS);
    localparam int CIDX_W      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam logic [31:0] NOP_WORD = 32'h0100_0000;
    localparam int ROW_GROUP   = 3;
    localparam int EXTRA_ROWS  = 2;

    localparam logic [2:0] CFG_ROWS  = 3'd0;
    localparam logic [2:0] CFG_TOTAL = 3'd1;
    localparam logic [2:0] CFG_MEM   = 3'd2;
    localparam logic [2:0] CFG_MUL   = 3'd3;
    localparam logic [2:0] CFG_FP    = 3'd4;
    localparam logic [2:0] CFG_LIMIT = 3'd5;

    localparam logic [1:0] CLS_ALU = 2'd0;
    localparam logic [1:0] CLS_MEM = 2'd1;
    localparam logic [1:0] CLS_MUL = 2'd2;
    localparam logic [1:0] CLS_FP  = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [31:0] instruction_word;
        logic [4:0]  source_one;
        logic [4:0]  source_two;
        logic [4:0]  destination;
        logic [1:0]  unit_class;
    } t_in_word;

    typedef struct packed {
        logic       accepted;
        logic [4:0] placed_row;
        logic [3:0] placed_column;
        logic [2:0] current_level;
        logic [5:0] context_count;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CTX, ST_DEP, ST_SCAN, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic clear;
        logic ctx;
        logic dep_step;
        logic scan_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_clear;
        logic is_nop;
        logic ctx_over;
        logic dep_done;
        logic dep_fail;
        logic scan_done;
    } t_status;
endpackage
`default_nettype wire

// File: rtl/rap_datapath.sv
// Datapath of the placer: grid occupancy, row write masks, context and result.
// Depends on rap_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rap_datapath (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [2:0]          i_cfg_index,
    input  wire [5:0]          i_cfg_data,
    input  rap_pkg::t_in_word  i_word,
    input  rap_pkg::t_cmd      i_cmd,
    output rap_pkg::t_status   o_status,
    output rap_pkg::t_out_word o_result
);
    localparam int RW = rap_pkg::ROW_W;
    localparam int CW = rap_pkg::COL_W;

    logic [4:0] r_rows_cfg, r_total_cfg, r_mem_cfg, r_mul_cfg, r_fp_cfg;
    logic [5:0] r_limit_cfg;

    logic [rap_pkg::MAX_COLUMNS-1:0] r_busy [rap_pkg::MAX_ROWS];
    logic [rap_pkg::NUM_REGS-1:0]    r_wmask [rap_pkg::MAX_ROWS];
    logic [rap_pkg::NUM_REGS-1:0]    r_ctx, r_rl, r_tctx, r_trl;
    logic [5:0] r_cnt;
    logic [2:0] r_lvl;
    rap_pkg::t_in_word r_in;
    logic [rap_pkg::NUM_REGS-1:0] r_b1, r_b2, r_bw;
    logic [RW-1:0] r_r, r_dest, r_rows;
    logic [CW-1:0] r_beg, r_end;
    logic r_acc, r_sdone;
    logic [4:0] r_prow;
    logic [3:0] r_pcol;

    function automatic logic [rap_pkg::NUM_REGS-1:0] reg_bit(input logic [4:0] r);
        logic [rap_pkg::NUM_REGS-1:0] b;
        b = '0;
        if (r != 5'd0 && 32'(r) < rap_pkg::NUM_REGS) b[r[$clog2(rap_pkg::NUM_REGS)-1:0]] = 1'b1;
        return b;
    endfunction

    function automatic logic [CW-1:0] ssub(input logic [CW-1:0] a, input logic [4:0] b);
        logic [5:0] a6;
        a6 = 6'(a);
        return (a6 > 6'(b)) ? CW'(a6 - 6'(b)) : '0;
    endfunction

    // Rounds a row up to the next group boundary; rows past the last group read as all ones.
    function automatic logic [RW-1:0] align_up(input logic [RW-1:0] x);
        logic [RW-1:0] a;
        a = '1;
        for (int q = rap_pkg::MAX_ROWS / rap_pkg::ROW_GROUP + 1; q >= 0; q--) begin
            if (32'(x) <= q * rap_pkg::ROW_GROUP) a = RW'(q * rap_pkg::ROW_GROUP);
        end
        return a;
    endfunction

    function automatic int row_level(input logic [RW-1:0] x);
        int d;
        d = 0;
        for (int q = 1; q <= rap_pkg::MAX_ROWS / rap_pkg::ROW_GROUP + 1; q++) begin
            if (32'(x) >= q * rap_pkg::ROW_GROUP) d = q;
        end
        return d;
    endfunction

    logic [CW-1:0] cols, fp_s, mul_s, mem_s, beg_c, end_c;
    logic [RW-1:0] rows_c;
    always_comb begin
        rows_c = (32'(r_rows_cfg) > rap_pkg::MAX_ROWS) ? RW'(rap_pkg::MAX_ROWS) : RW'(r_rows_cfg);
        cols   = (32'(r_total_cfg) > rap_pkg::MAX_COLUMNS) ? CW'(rap_pkg::MAX_COLUMNS)
                                                           : CW'(r_total_cfg);
        fp_s   = ssub(cols, r_fp_cfg);
        mul_s  = ssub(fp_s, r_mul_cfg);
        mem_s  = ssub(mul_s, r_mem_cfg);
        unique case (r_in.unit_class)
            rap_pkg::CLS_ALU: begin beg_c = '0;    end_c = mem_s; end
            rap_pkg::CLS_MEM: begin beg_c = mem_s; end_c = mul_s; end
            rap_pkg::CLS_MUL: begin beg_c = mul_s; end_c = fp_s;  end
            default:          begin beg_c = fp_s;  end_c = cols;  end
        endcase
    end

    // Context update computed from the registered item.
    logic [rap_pkg::NUM_REGS-1:0] n_tctx, n_trl;
    logic [5:0] n_cnt;
    always_comb begin
        n_tctx = r_ctx;
        n_trl  = r_rl;
        n_cnt  = r_cnt;
        if (r_b1 != '0 && (n_tctx & r_b1) == '0) begin
            n_tctx |= r_b1; n_trl |= r_b1; if (n_cnt < 6'd63) n_cnt = n_cnt + 6'd1;
        end
        if (r_b2 != '0 && (n_tctx & r_b2) == '0) begin
            n_tctx |= r_b2; n_trl |= r_b2; if (n_cnt < 6'd63) n_cnt = n_cnt + 6'd1;
        end
        if (r_bw != '0 && (n_tctx & r_bw) == '0) begin
            n_tctx |= r_bw; if (n_cnt < 6'd63) n_cnt = n_cnt + 6'd1;
        end
    end

    // Scan step over one row: row (aligned for non-ALU classes) and first free column in range.
    logic [RW-1:0] adest;
    logic [rap_pkg::RIDX_W-1:0] aidx;
    logic found;
    logic [CW-1:0] fcol;
    logic [rap_pkg::MAX_COLUMNS-1:0] busy_row;
    logic is_alu;
    logic [RW:0] last;
    always_comb begin
        is_alu = (r_in.unit_class == rap_pkg::CLS_ALU);
        adest  = r_dest;
        if (!is_alu) adest = align_up(r_dest);
        aidx = adest[rap_pkg::RIDX_W-1:0];
        busy_row = (adest < r_rows) ? r_busy[aidx] : '1;
        found = 1'b0;
        fcol  = '0;
        for (int j = rap_pkg::MAX_COLUMNS - 1; j >= 0; j--) begin
            if (CW'(j) >= r_beg && CW'(j) < r_end && !busy_row[j]) begin
                found = 1'b1;
                fcol  = CW'(j);
            end
        end
        last = (RW + 1)'(adest) + (is_alu ? '0 : (RW + 1)'(rap_pkg::EXTRA_ROWS));
    end

    logic [rap_pkg::RIDX_W-1:0] ridx;
    assign ridx = r_r[rap_pkg::RIDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= 5'd24; r_total_cfg <= 5'd16; r_mem_cfg <= 5'd2;
            r_mul_cfg <= 5'd2; r_fp_cfg <= 5'd0; r_limit_cfg <= 6'd32;
            for (int i = 0; i < rap_pkg::MAX_ROWS; i++) begin
                r_busy[i] <= '0; r_wmask[i] <= '0;
            end
            r_ctx <= '0; r_rl <= '0; r_cnt <= '0; r_lvl <= '0;
            r_sdone <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rap_pkg::CFG_ROWS:  r_rows_cfg  <= i_cfg_data[4:0];
                    rap_pkg::CFG_TOTAL: r_total_cfg <= i_cfg_data[4:0];
                    rap_pkg::CFG_MEM:   r_mem_cfg   <= i_cfg_data[4:0];
                    rap_pkg::CFG_MUL:   r_mul_cfg   <= i_cfg_data[4:0];
                    rap_pkg::CFG_FP:    r_fp_cfg    <= i_cfg_data[4:0];
                    rap_pkg::CFG_LIMIT: r_limit_cfg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_in <= i_word;
                r_b1 <= reg_bit(i_word.source_one);
                r_b2 <= reg_bit(i_word.source_two);
                r_bw <= reg_bit(i_word.destination);
                r_acc <= 1'b0; r_prow <= '0; r_pcol <= '0;
                r_sdone <= 1'b0;
            end
            if (i_cmd.clear) begin
                for (int i = 0; i < rap_pkg::MAX_ROWS; i++) begin
                    r_busy[i] <= '0; r_wmask[i] <= '0;
                end
                r_ctx <= '0; r_rl <= '0; r_cnt <= '0; r_lvl <= '0;
            end
            if (i_cmd.ctx) begin
                r_tctx <= n_tctx; r_trl <= n_trl; r_cnt <= n_cnt;
                r_r <= '0; r_dest <= '0; r_rows <= rows_c;
                r_beg <= beg_c; r_end <= end_c;
            end
            if (i_cmd.dep_step && r_r < r_rows) begin
                if ((r_wmask[ridx] & (r_b1 | r_b2)) != '0) r_dest <= r_r + RW'(1);
                r_r <= r_r + RW'(1);
            end
            if (i_cmd.scan_step && !r_sdone) begin
                if (adest >= r_rows) begin
                    r_sdone <= 1'b1;
                end else if (found) begin
                    r_sdone <= 1'b1;
                    if (last < (RW + 1)'(r_rows)) begin
                        for (int k = 0; k <= rap_pkg::EXTRA_ROWS; k++) begin
                            if (is_alu ? (k == 0) : 1'b1)
                                r_busy[aidx + rap_pkg::RIDX_W'(k)][fcol[rap_pkg::CIDX_W-1:0]]
                                    <= 1'b1;
                        end
                        r_wmask[last[rap_pkg::RIDX_W-1:0]] <= r_wmask[last[rap_pkg::RIDX_W-1:0]]
                                                             | r_bw;
                        if (32'(r_lvl) < 32'(row_level(adest)) && r_lvl < 3'd7)
                            r_lvl <= r_lvl + 3'd1;
                        r_ctx <= r_tctx; r_rl <= r_trl;
                        r_acc <= 1'b1;
                        r_prow <= 5'(last);
                        r_pcol <= 4'(fcol);
                    end
                end else begin
                    r_dest <= adest + RW'(1);
                end
            end
            if (i_cmd.finish && (r_in.kind == 1'b0 || r_in.instruction_word == rap_pkg::NOP_WORD))
                r_acc <= 1'b1;
        end
    end

    assign o_status.is_clear  = (r_in.kind == 1'b0);
    assign o_status.is_nop    = (r_in.instruction_word == rap_pkg::NOP_WORD);
    assign o_status.ctx_over  = (r_cnt > r_limit_cfg);
    assign o_status.dep_done  = (r_r >= r_rows);
    assign o_status.dep_fail  = (r_dest >= r_rows);
    assign o_status.scan_done = r_sdone;

    assign o_result.accepted      = r_acc;
    assign o_result.placed_row    = r_prow;
    assign o_result.placed_column = r_pcol;
    assign o_result.current_level = r_lvl;
    assign o_result.context_count = r_cnt;
endmodule
`default_nettype wire

// File: rtl/rap_controller.sv
// Controller state machine of the placer: sequences load, context, search, scan, output.
// Depends on rap_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rap_controller (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    input  rap_pkg::t_status i_status,
    output rap_pkg::t_cmd    o_cmd
);
    rap_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= rap_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rap_pkg::ST_IDLE: if (i_in_valid) n_state = rap_pkg::ST_CTX;
            rap_pkg::ST_CTX: begin
                if (i_status.is_clear || i_status.is_nop) n_state = rap_pkg::ST_OUT;
                else                                      n_state = rap_pkg::ST_DEP;
            end
            rap_pkg::ST_DEP: begin
                if (i_status.ctx_over)      n_state = rap_pkg::ST_OUT;
                else if (i_status.dep_done) n_state = i_status.dep_fail ? rap_pkg::ST_OUT
                                                                        : rap_pkg::ST_SCAN;
            end
            rap_pkg::ST_SCAN: if (i_status.scan_done) n_state = rap_pkg::ST_OUT;
            rap_pkg::ST_OUT:  if (!i_out_stall) n_state = rap_pkg::ST_IDLE;
            default: n_state = rap_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_stall  = (r_state != rap_pkg::ST_IDLE);
        o_out_valid = (r_state == rap_pkg::ST_OUT);
        unique case (r_state)
            rap_pkg::ST_IDLE: o_cmd.load = i_in_valid;
            rap_pkg::ST_CTX: begin
                o_cmd.clear  = i_status.is_clear;
                o_cmd.ctx    = !i_status.is_clear && !i_status.is_nop;
                o_cmd.finish = i_status.is_clear || i_status.is_nop;
            end
            rap_pkg::ST_DEP:  o_cmd.dep_step  = !i_status.ctx_over;
            rap_pkg::ST_SCAN: o_cmd.scan_step = 1'b1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/reconfigurable_array_placer_core.sv
// Top level of the reconfigurable array placer: controller plus datapath.
// Depends on rap_pkg, rap_controller and rap_datapath.
//  channel | direction | handshake              | payload
//  input   | in        | i_in_valid / o_in_stall  | i_in_word
//  output  | out       | o_out_valid / i_out_stall| o_out_word
//  config  | in        | i_cfg_we               | i_cfg_index, i_cfg_data
// A clear or NOP word goes from the context state straight to its result; a placement
// first passes the row-by-row dependency search and then the row-by-row column scan.
// A word over the context limit, or one rejected by the dependency search, gets its
// result without a scan. Reset is synchronous and active low and clears the grid and
// context. A stalled result holds and no new word is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module reconfigurable_array_placer_core (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  rap_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output rap_pkg::t_out_word o_out_word,
    input  wire                i_cfg_we,
    input  wire [2:0]          i_cfg_index,
    input  wire [5:0]          i_cfg_data
);
    rap_pkg::t_cmd    cmd;
    rap_pkg::t_status status;

    rap_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_status(status), .o_cmd(cmd)
    );

    rap_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .i_word(i_in_word), .i_cmd(cmd), .o_status(status),
        .o_result(o_out_word)
    );
endmodule
`default_nettype wire

// File: rtl/rap_checker.sv
// Port-level checker for the placer, bound to the top level.
// Depends on rap_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rap_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_valid,
    input wire                o_in_stall,
    input wire                o_out_valid,
    input wire                i_out_stall,
    input rap_pkg::t_out_word o_out_word
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result changed under stall");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !o_out_valid)
        else $error("result without work");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.accepted |->
            o_out_word.placed_row == 5'd0 && o_out_word.placed_column == 4'd0)
        else $error("rejected word carries a place");
endmodule

bind reconfigurable_array_placer_core rap_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word)
);
`default_nettype wire
